// ===== hw/rtl/ssba_pkg.sv =====
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared widths, limits and register indexes of the scaled sensor block
// average.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int GAIN_W   = 8;
  localparam int OFFSET_W = 15;
  localparam int SHIFT_W  = 4;
  localparam int VALUE_W  = 15;
  localparam int CUT_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_SHIFT  = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 15'h7fff;

endpackage

// ===== hw/rtl/ssba_cond.sv =====
// ----------------------------------------------------------------------------
// ssba_cond
// Conditions one scaled sample: reads the 16-bit cut product as signed,
// subtracts the channel bias and clamps negative results to zero.
// ----------------------------------------------------------------------------
module ssba_cond (
  input  logic [ssba_pkg::CUT_W-1:0]    cut_i,
  input  logic [ssba_pkg::OFFSET_W-1:0] offset_i,
  output logic [ssba_pkg::VALUE_W-1:0]  value_o
);
  import ssba_pkg::*;

  logic signed [CUT_W:0] diff;

  // exact subtraction in 17 bits, no second wrap
  assign diff = $signed({cut_i[CUT_W-1], cut_i}) - $signed({2'b00, offset_i});

  always_comb begin
    if (diff[CUT_W]) begin
      value_o = '0;
    end else begin
      value_o = diff[VALUE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/scaled_sensor_block_average.sv =====
// ----------------------------------------------------------------------------
// scaled_sensor_block_average
// Boxcar average decimator for a current and a voltage converter channel.
// ----------------------------------------------------------------------------
// Takes one sample pair per clock and gives one pair of means for every
// 2^average_shift pairs (average_shift above MAX_SHIFT acts as MAX_SHIFT).
// Two register stages: the gain products are registered at the input
// transfer, and when the product stage passes them on they are conditioned,
// the sums are updated and, at the end of a period, the result register is
// loaded, so a result is registered when the pair that closes its period
// leaves the product stage. A stalled result holds back only a pair that
// closes the following period; other pairs keep flowing at one per clock.
module scaled_sensor_block_average #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SHIFT   = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          current_sample_i,
  input  logic [SAMPLE_BITS-1:0]          voltage_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ssba_pkg::VALUE_W-1:0]    current_mean_o,
  output logic [ssba_pkg::VALUE_W-1:0]    voltage_mean_o
);
  import ssba_pkg::*;

  localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
  localparam int SUM_W   = VALUE_W + MAX_SHIFT;
  localparam int TALLY_W = MAX_SHIFT + 1;
  localparam int SH_W    = $clog2(MAX_SHIFT + 1);
  localparam int CMP_W   = (SH_W > SHIFT_W) ? SH_W : SHIFT_W;

  // configuration
  logic [GAIN_W-1:0]   cur_gain_q, vol_gain_q;
  logic [OFFSET_W-1:0] cur_offset_q, vol_offset_q;
  logic [SHIFT_W-1:0]  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_gain_q   <= GAIN_RESET;
      vol_gain_q   <= GAIN_RESET;
      cur_offset_q <= '0;
      vol_offset_q <= '0;
      shift_q      <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CURRENT_GAIN:   cur_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_VOLTAGE_GAIN:   vol_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_CURRENT_OFFSET: cur_offset_q <= cfg_data_i[OFFSET_W-1:0];
        REG_VOLTAGE_OFFSET: vol_offset_q <= cfg_data_i[OFFSET_W-1:0];
        REG_AVERAGE_SHIFT:  shift_q      <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective shift, limited to MAX_SHIFT
  logic [CMP_W-1:0] shift_ext;
  logic [SH_W-1:0]  sh_eff;

  assign shift_ext = CMP_W'(shift_q);
  assign sh_eff    = (shift_ext > CMP_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : SH_W'(shift_ext);

  // product stage
  logic [PROD_W-1:0] cur_prod, vol_prod;
  logic              p_vld_q, p_vld_d;
  logic [CUT_W-1:0]  cur_cut_q, vol_cut_q;
  logic              in_xfer, p_take;

  assign cur_prod   = PROD_W'(current_sample_i) * PROD_W'(cur_gain_q);
  assign vol_prod   = PROD_W'(voltage_sample_i) * PROD_W'(vol_gain_q);
  assign in_stall_o = p_vld_q && !p_take;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_xfer) begin
      p_vld_d = 1'b1;
    end else if (p_take) begin
      p_vld_d = 1'b0;
    end else begin
      p_vld_d = p_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= p_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_cut_q <= cur_prod[CUT_W-1:0];
      vol_cut_q <= vol_prod[CUT_W-1:0];
    end
  end

  // accumulate stage
  logic [VALUE_W-1:0] cur_value, vol_value;

  ssba_cond u_cur_cond (
    .cut_i    (cur_cut_q),
    .offset_i (cur_offset_q),
    .value_o  (cur_value)
  );

  ssba_cond u_vol_cond (
    .cut_i    (vol_cut_q),
    .offset_i (vol_offset_q),
    .value_o  (vol_value)
  );

  logic [SUM_W-1:0]   cur_sum_q, vol_sum_q, cur_sum_new, vol_sum_new;
  logic [SUM_W-1:0]   cur_shifted, vol_shifted;
  logic [TALLY_W-1:0] tally_q, tally_new, tally_limit;
  logic               emit, out_free;
  logic               out_vld_q, out_vld_d;
  logic [VALUE_W-1:0] cur_mean_q, vol_mean_q, cur_mean_d, vol_mean_d;

  assign cur_sum_new = cur_sum_q + SUM_W'(cur_value);
  assign vol_sum_new = vol_sum_q + SUM_W'(vol_value);
  assign tally_new   = tally_q + TALLY_W'(1);
  assign tally_limit = TALLY_W'(1) << sh_eff;
  assign emit        = tally_new >= tally_limit;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign p_take      = p_vld_q && (!emit || out_free);

  assign cur_shifted = cur_sum_new >> sh_eff;
  assign vol_shifted = vol_sum_new >> sh_eff;
  // saturates when the period was cut short by a lowered shift
  assign cur_mean_d  = (|cur_shifted[SUM_W-1:VALUE_W]) ? VALUE_MAX
                                                        : cur_shifted[VALUE_W-1:0];
  assign vol_mean_d  = (|vol_shifted[SUM_W-1:VALUE_W]) ? VALUE_MAX
                                                        : vol_shifted[VALUE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_sum_q <= '0;
      vol_sum_q <= '0;
      tally_q   <= '0;
    end else if (p_take) begin
      if (emit) begin
        cur_sum_q <= '0;
        vol_sum_q <= '0;
        tally_q   <= '0;
      end else begin
        cur_sum_q <= cur_sum_new;
        vol_sum_q <= vol_sum_new;
        tally_q   <= tally_new;
      end
    end
  end

  // result register
  always_comb begin
    if (p_take && emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_take && emit) begin
      cur_mean_q <= cur_mean_d;
      vol_mean_q <= vol_mean_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign current_mean_o = cur_mean_q;
  assign voltage_mean_o = vol_mean_q;

  // a period never runs past the longest allowed length
  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q < (TALLY_W'(1) << MAX_SHIFT))
    else $error("sample tally beyond period length");

  // closing a period clears the count
  a_tally_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_take && emit |=> tally_q == '0)
    else $error("tally not cleared after result");

  // with no averaging every pair closes a period
  a_shift_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_take && sh_eff == '0 |-> emit)
    else $error("missing result at shift zero");

  // a pair held back in the product stage keeps its data
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q && !p_take |=> p_vld_q && $stable(cur_cut_q) && $stable(vol_cut_q))
    else $error("held product changed");

endmodule
